/* design/bcs_pkg.sv */
// shared types, constants and helper functions for the block compression selector
package bcs_pkg;

   localparam int VALUE_W = 64;
   localparam int VBYTES_W = 4;
   localparam int RATIO_W = 18;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 18;
   localparam int SIZE_OUT_W = 21;
   localparam int OFFSET_W = 4;
   localparam int DBITS_W = 7;
   localparam int DEFAULT_MAX_BLOCK_ROWS = 8192;

   localparam logic [VBYTES_W-1:0] VALUE_BYTES_RESET = 4'd8;
   localparam logic [RATIO_W-1:0] MAX_RATIO_RESET = 18'd65536;

   typedef enum logic [1:0] {
      ENC_RAW = 2'd0,
      ENC_CONST = 2'd1,
      ENC_RLE = 2'd2,
      ENC_DELTA = 2'd3
   } encoding_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VALUE_BYTES = 2'd0,
      CSR_VALUES_SIGNED = 2'd1,
      CSR_MAX_RATIO = 2'd2
   } csr_index_type;

   // unsupported widths round up to the next supported byte count; widths above 8 map to 8
   function automatic logic [VBYTES_W-1:0] width_bytes(input logic [VBYTES_W-1:0] vb);
      logic [VBYTES_W-1:0] nb;
      if (vb <= 4'd1) begin
         nb = 4'd1;
      end else if (vb == 4'd2) begin
         nb = 4'd2;
      end else if (vb <= 4'd4) begin
         nb = 4'd4;
      end else begin
         nb = 4'd8;
      end
      return nb;
   endfunction

   function automatic logic [VALUE_W-1:0] width_mask(input logic [VBYTES_W-1:0] nb);
      logic [VALUE_W-1:0] m;
      case (nb)
         4'd1: m = 64'h0000_0000_0000_00FF;
         4'd2: m = 64'h0000_0000_0000_FFFF;
         4'd4: m = 64'h0000_0000_FFFF_FFFF;
         default: m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

   // flipping the sign bit lets an unsigned compare follow two's complement order
   function automatic logic [VALUE_W-1:0] order_key(input logic [VALUE_W-1:0] v,
                                                    input logic [VBYTES_W-1:0] nb,
                                                    input logic sgn);
      logic [VALUE_W-1:0] m;
      logic [VALUE_W-1:0] k;
      m = width_mask(nb);
      k = v & m;
      if (sgn) begin
         k = k ^ ((m >> 1) + 64'd1);
      end
      return k;
   endfunction

   function automatic logic [DBITS_W-1:0] bit_length(input logic [VALUE_W-1:0] x);
      logic [DBITS_W-1:0] n;
      n = '0;
      for (int i = 0; i < VALUE_W; i++) begin
         if (x[i]) begin
            n = DBITS_W'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

/* design/bcs_if.sv */
// valid/ready channel interfaces for column values and encoding results
interface bcs_req_if;
   logic valid;
   logic ready;
   logic [bcs_pkg::VALUE_W-1:0] value;
   logic last;

   modport source (output valid, output value, output last, input ready);
   modport sink (input valid, input value, input last, output ready);
endinterface

interface bcs_rsp_if;
   logic valid;
   logic ready;
   bcs_pkg::encoding_type encoding;
   logic [bcs_pkg::SIZE_OUT_W-1:0] compressed_size;
   logic [bcs_pkg::OFFSET_W-1:0] offset_bytes;
   logic [bcs_pkg::VALUE_W-1:0] delta_base;
   logic [bcs_pkg::DBITS_W-1:0] delta_bits;

   modport source (output valid, output encoding, output compressed_size, output offset_bytes,
                   output delta_base, output delta_bits, input ready);
   modport sink (input valid, input encoding, input compressed_size, input offset_bytes,
                 input delta_base, input delta_bits, output ready);
endinterface

/* design/block_compression_selector.sv */
// block compression selector: running block statistics and encoding choice pipeline
// the statistics of a closed block pass through the result stages into the result register
// throughput: one value per cycle unless stalled; statistics and result stages are registered
// a full result register with rsp not ready stalls the stages behind it and then req
// reset (synchronous, active high) empties the pipeline, starts a new block and restores
// value_bytes 8, values_signed 0 and max_ratio_q16 1.0
module block_compression_selector #(
   parameter int MAX_BLOCK_ROWS = bcs_pkg::DEFAULT_MAX_BLOCK_ROWS
) (
   input logic clock,
   input logic reset,
   bcs_req_if.sink req_ch,
   bcs_rsp_if.source rsp_ch,
   input logic csr_we,
   input logic [bcs_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [bcs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int ROW_W = $clog2(MAX_BLOCK_ROWS + 1);
   localparam int UNC_W = ROW_W + 3;
   localparam int SIZE_W = ROW_W + 4;
   localparam int TB_W = ROW_W + 7;
   localparam int CEIL_W = TB_W - 6;
   localparam int LIM_W = ROW_W + 21;
   localparam logic [ROW_W-1:0] MAX_ROWS_C = ROW_W'(MAX_BLOCK_ROWS);

   localparam int VW = bcs_pkg::VALUE_W;
   localparam int NBW = bcs_pkg::VBYTES_W;

   // configuration registers
   logic [NBW-1:0] value_bytes_ff;
   logic values_signed_ff;
   logic [bcs_pkg::RATIO_W-1:0] max_ratio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_bytes_ff <= bcs_pkg::VALUE_BYTES_RESET;
         values_signed_ff <= 1'b0;
         max_ratio_ff <= bcs_pkg::MAX_RATIO_RESET;
      end else if (csr_we) begin
         case (bcs_pkg::csr_index_type'(csr_index))
            bcs_pkg::CSR_VALUE_BYTES: value_bytes_ff <= csr_wdata[NBW-1:0];
            bcs_pkg::CSR_VALUES_SIGNED: values_signed_ff <= csr_wdata[0];
            bcs_pkg::CSR_MAX_RATIO: max_ratio_ff <= csr_wdata[bcs_pkg::RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   logic [NBW-1:0] nb;
   logic [VW-1:0] mask;
   assign nb = bcs_pkg::width_bytes(value_bytes_ff);
   assign mask = bcs_pkg::width_mask(nb);

   // stage enables, back to front
   logic en1, en2, en3, en4, en5;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;

   assign en5 = !out_valid_ff || rsp_ch.ready;
   assign en4 = !s4_valid_ff || en5;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_ch.ready = en1;

   // running block statistics
   logic at_start_ff;
   logic [VW-1:0] block_min_ff, block_max_ff, prev_ff;
   logic [ROW_W-1:0] runs_ff, rows_ff;
   logic [VW-1:0] block_min_in, block_max_in, v_in;
   logic [ROW_W-1:0] runs_in, rows_in;
   logic [VW-1:0] key_v, key_min, key_max;
   logic accept, close;

   assign accept = req_ch.valid && req_ch.ready;
   assign v_in = req_ch.value & mask;
   assign key_v = bcs_pkg::order_key(v_in, nb, values_signed_ff);
   assign key_min = bcs_pkg::order_key(block_min_ff, nb, values_signed_ff);
   assign key_max = bcs_pkg::order_key(block_max_ff, nb, values_signed_ff);

   always_comb begin
      if (at_start_ff) begin
         block_min_in = v_in;
         block_max_in = v_in;
         runs_in = ROW_W'(1);
         rows_in = ROW_W'(1);
      end else begin
         block_min_in = (key_v < key_min) ? v_in : block_min_ff;
         block_max_in = (key_v > key_max) ? v_in : block_max_ff;
         runs_in = (v_in != (prev_ff & mask)) ? runs_ff + ROW_W'(1) : runs_ff;
         rows_in = rows_ff + ROW_W'(1);
      end
   end

   // a full block closes as if last were set
   assign close = req_ch.last || (rows_in >= MAX_ROWS_C);

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
         block_min_ff <= '0;
         block_max_ff <= '0;
         prev_ff <= '0;
         runs_ff <= '0;
         rows_ff <= '0;
      end else if (accept) begin
         at_start_ff <= close;
         block_min_ff <= block_min_in;
         block_max_ff <= block_max_in;
         prev_ff <= v_in;
         runs_ff <= runs_in;
         rows_ff <= rows_in;
      end
   end

   // stage 1: snapshot of the closed block
   logic [VW-1:0] s1_min_ff, s1_max_ff;
   logic [ROW_W-1:0] s1_rows_ff, s1_runs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= accept && close;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_min_ff <= block_min_in;
         s1_max_ff <= block_max_in;
         s1_rows_ff <= rows_in;
         s1_runs_ff <= runs_in;
      end
   end

   // stage 2: range, offset width, raw and run-length sizes
   logic [VW-1:0] s2_diff_in, s2_mn_in, s2_diff_ff, s2_mn_ff;
   logic [NBW-1:0] s2_ob_in, s2_ob_ff;
   logic [UNC_W-1:0] s2_unc_in, s2_unc_ff;
   logic [SIZE_W-1:0] s2_rle_in, s2_rle_ff;
   logic [ROW_W-1:0] s2_rows_ff;
   logic [32:0] rows_wide;

   assign rows_wide = 33'(s1_rows_ff);

   always_comb begin
      s2_diff_in = (s1_max_ff - s1_min_ff) & mask;
      s2_mn_in = s1_min_ff & mask;
      if (rows_wide <= 33'd255) begin
         s2_ob_in = 4'd1;
      end else if (rows_wide <= 33'd65535) begin
         s2_ob_in = 4'd2;
      end else if (rows_wide <= 33'h0_FFFF_FFFF) begin
         s2_ob_in = 4'd4;
      end else begin
         s2_ob_in = 4'd8;
      end
      s2_unc_in = UNC_W'(nb) * UNC_W'(s1_rows_ff);
      s2_rle_in = (SIZE_W'(nb) + SIZE_W'(s2_ob_in)) * SIZE_W'(s1_runs_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_diff_ff <= s2_diff_in;
         s2_mn_ff <= s2_mn_in;
         s2_ob_ff <= s2_ob_in;
         s2_unc_ff <= s2_unc_in;
         s2_rle_ff <= s2_rle_in;
         s2_rows_ff <= s1_rows_ff;
      end
   end

   // stage 3: delta bit width and the ratio limit
   logic [bcs_pkg::DBITS_W-1:0] s3_dbits_in, s3_dbits_ff;
   logic [LIM_W-1:0] s3_limit_in, s3_limit_ff;
   logic s3_zero_ff;
   logic [VW-1:0] s3_mn_ff;
   logic [NBW-1:0] s3_ob_ff;
   logic [UNC_W-1:0] s3_unc_ff;
   logic [SIZE_W-1:0] s3_rle_ff;
   logic [ROW_W-1:0] s3_rows_ff;

   assign s3_dbits_in = bcs_pkg::bit_length(s2_diff_ff);
   assign s3_limit_in = LIM_W'(max_ratio_ff) * LIM_W'(s2_unc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_dbits_ff <= s3_dbits_in;
         s3_limit_ff <= s3_limit_in;
         s3_zero_ff <= (s2_diff_ff == '0);
         s3_mn_ff <= s2_mn_ff;
         s3_ob_ff <= s2_ob_ff;
         s3_unc_ff <= s2_unc_ff;
         s3_rle_ff <= s2_rle_ff;
         s3_rows_ff <= s2_rows_ff;
      end
   end

   // stage 4: packed delta bits
   logic [TB_W-1:0] s4_tb_in, s4_tb_ff;
   logic [bcs_pkg::DBITS_W-1:0] s4_dbits_ff;
   logic [LIM_W-1:0] s4_limit_ff;
   logic s4_zero_ff;
   logic [VW-1:0] s4_mn_ff;
   logic [NBW-1:0] s4_ob_ff;
   logic [UNC_W-1:0] s4_unc_ff;
   logic [SIZE_W-1:0] s4_rle_ff;

   assign s4_tb_in = TB_W'(s3_dbits_ff) * TB_W'(s3_rows_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en4) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_tb_ff <= s4_tb_in;
         s4_dbits_ff <= s3_dbits_ff;
         s4_limit_ff <= s3_limit_ff;
         s4_zero_ff <= s3_zero_ff;
         s4_mn_ff <= s3_mn_ff;
         s4_ob_ff <= s3_ob_ff;
         s4_unc_ff <= s3_unc_ff;
         s4_rle_ff <= s3_rle_ff;
      end
   end

   // stage 5: delta size, encoding choice and ratio test into the result register
   logic [TB_W-1:0] tb_round;
   logic [CEIL_W-1:0] words;
   logic [SIZE_W-1:0] delta_size;
   logic [SIZE_W-1:0] sel_size;
   bcs_pkg::encoding_type enc_in, enc_ff;
   logic [bcs_pkg::SIZE_OUT_W-1:0] size_in, size_ff;
   logic [bcs_pkg::OFFSET_W-1:0] ob_in, ob_ff;
   logic [VW-1:0] base_in, base_ff;
   logic [bcs_pkg::DBITS_W-1:0] bits_in, bits_ff;

   always_comb begin
      tb_round = s4_tb_ff + TB_W'(63);
      words = tb_round[TB_W-1:6];
      delta_size = SIZE_W'(nb) + SIZE_W'(1) + ((SIZE_W'(words) + SIZE_W'(1)) << 3);
      ob_in = '0;
      base_in = '0;
      bits_in = '0;
      if (s4_zero_ff) begin
         enc_in = bcs_pkg::ENC_CONST;
         sel_size = SIZE_W'(nb);
      end else if (s4_rle_ff < delta_size) begin
         enc_in = bcs_pkg::ENC_RLE;
         sel_size = s4_rle_ff;
         ob_in = s4_ob_ff;
      end else begin
         enc_in = bcs_pkg::ENC_DELTA;
         sel_size = delta_size;
         base_in = s4_mn_ff;
         bits_in = s4_dbits_ff;
      end
      size_in = bcs_pkg::SIZE_OUT_W'(sel_size);
      // ratio above the limit falls back to raw
      if ({LIM_W'(sel_size), 16'b0} > {16'b0, s4_limit_ff}) begin
         enc_in = bcs_pkg::ENC_RAW;
         size_in = bcs_pkg::SIZE_OUT_W'(s4_unc_ff);
         ob_in = '0;
         base_in = '0;
         bits_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en5) begin
         out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         enc_ff <= enc_in;
         size_ff <= size_in;
         ob_ff <= ob_in;
         base_ff <= base_in;
         bits_ff <= bits_in;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.encoding = enc_ff;
   assign rsp_ch.compressed_size = size_ff;
   assign rsp_ch.offset_bytes = ob_ff;
   assign rsp_ch.delta_base = base_ff;
   assign rsp_ch.delta_bits = bits_ff;

endmodule

/* design/bcs_checker.sv */
// port-level assertions for the block compression selector, bound to the top level
module bcs_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [1:0] rsp_encoding,
   input logic [bcs_pkg::SIZE_OUT_W-1:0] rsp_compressed_size,
   input logic [bcs_pkg::OFFSET_W-1:0] rsp_offset_bytes,
   input logic [bcs_pkg::VALUE_W-1:0] rsp_delta_base,
   input logic [bcs_pkg::DBITS_W-1:0] rsp_delta_bits
);

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_encoding)
         && $stable(rsp_compressed_size) && $stable(rsp_offset_bytes)
         && $stable(rsp_delta_base) && $stable(rsp_delta_bits))
      else $error("stalled result changed");

   // reset empties the pipeline and opens the input
   assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_encoding == 2'(bcs_pkg::ENC_RLE) |->
         rsp_offset_bytes != '0 && rsp_delta_bits == '0 && rsp_delta_base == '0)
      else $error("run-length result with delta fields or no offset width");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_encoding == 2'(bcs_pkg::ENC_DELTA) |->
         rsp_delta_bits != '0 && rsp_offset_bytes == '0)
      else $error("delta result with bad bit width or offset width");

endmodule

bind block_compression_selector bcs_checker u_bcs_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_encoding(rsp_ch.encoding),
   .rsp_compressed_size(rsp_ch.compressed_size),
   .rsp_offset_bytes(rsp_ch.offset_bytes),
   .rsp_delta_base(rsp_ch.delta_base),
   .rsp_delta_bits(rsp_ch.delta_bits)
);
